### rtl/core/pkr_pkg.sv
// Shared constants, types and the reserved-word table of the keyword recognizer.
package pkr_pkg;

  localparam int MAX_KEYWORD_LEN = 9;
  localparam int LEN_W           = $clog2(MAX_KEYWORD_LEN + 2);
  localparam int IDX_W           = $clog2(MAX_KEYWORD_LEN);

  localparam int KW_COUNT   = 35;
  localparam int KW_MAX_LEN = 9;
  localparam int KW_LEN_W   = 4;
  localparam int CODE_W     = 6;

  localparam logic [CODE_W-1:0] CODE_IDENT = '0;

  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] UPPER_LAST  = 8'd90;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef logic [7:0] char_t;
  typedef char_t [KW_MAX_LEN-1:0] kw_text_t;

  // Text is right-justified: the first letter sits in the highest used byte.
  typedef struct packed {
    logic [KW_LEN_W-1:0] len;
    kw_text_t            text;
  } kw_entry_t;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{4'd2, kw_text_t'("do")},     '{4'd2, kw_text_t'("if")},
    '{4'd2, kw_text_t'("in")},     '{4'd2, kw_text_t'("of")},
    '{4'd2, kw_text_t'("or")},     '{4'd2, kw_text_t'("to")},
    '{4'd3, kw_text_t'("and")},    '{4'd3, kw_text_t'("div")},
    '{4'd3, kw_text_t'("end")},    '{4'd3, kw_text_t'("for")},
    '{4'd3, kw_text_t'("mod")},    '{4'd3, kw_text_t'("nil")},
    '{4'd3, kw_text_t'("not")},    '{4'd3, kw_text_t'("set")},
    '{4'd3, kw_text_t'("var")},
    '{4'd4, kw_text_t'("case")},   '{4'd4, kw_text_t'("else")},
    '{4'd4, kw_text_t'("file")},   '{4'd4, kw_text_t'("goto")},
    '{4'd4, kw_text_t'("then")},   '{4'd4, kw_text_t'("type")},
    '{4'd4, kw_text_t'("with")},
    '{4'd5, kw_text_t'("array")},  '{4'd5, kw_text_t'("begin")},
    '{4'd5, kw_text_t'("const")},  '{4'd5, kw_text_t'("label")},
    '{4'd5, kw_text_t'("until")},  '{4'd5, kw_text_t'("while")},
    '{4'd6, kw_text_t'("downto")}, '{4'd6, kw_text_t'("packed")},
    '{4'd6, kw_text_t'("record")}, '{4'd6, kw_text_t'("repeat")},
    '{4'd7, kw_text_t'("program")},
    '{4'd8, kw_text_t'("function")},
    '{4'd9, kw_text_t'("procedure")}
  };

  function automatic char_t fold_lower(input char_t c);
    if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

### rtl/core/pkr_if.sv
// Valid/ready channel interfaces for character beats and token beats.
interface pkr_in_if;
  logic                valid;
  logic                ready;
  pkr_pkg::char_t      ch;
  logic                last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface pkr_out_if;
  logic                        valid;
  logic                        ready;
  logic [pkr_pkg::CODE_W-1:0]  token_code;

  modport source (output valid, output token_code, input ready);
  modport sink   (input valid, input token_code, output ready);
endinterface

### rtl/core/pascal_keyword_recognizer.sv
// Top level of the Pascal reserved-word recognizer.
//
// Feed the characters of one already delimited word, one byte per beat on
// in_bus, with last set on the final byte. Each byte is folded to lower case
// (only 'A'..'Z' change) and held in a nine-byte word buffer; a length counter
// advances per byte and saturates one past the buffer depth. On the last byte
// one token beat leaves on out_bus: 0 for an identifier, 1..35 for a reserved
// word in table order (do, if, in, of, or, to, and, div, ... program,
// function, procedure). Words of one letter or longer than nine always give 0.
// Rate: one byte per clock, sustained unless a token waits untaken. The keyword
// compare runs in the same cycle as the final byte, between the word buffer and
// the token register, so a token appears in the cycle after its last byte is
// taken. The token register decouples the two sides: while it holds an untaken
// token, input is stalled only if out_bus.ready is low. Splitting text into
// words is the caller's job.
module pascal_keyword_recognizer (
  input  logic              clk,
  input  logic              rst_n,
  pkr_in_if.sink            in_bus,
  pkr_out_if.source         out_bus
);

  localparam logic [pkr_pkg::LEN_W-1:0] LEN_SAT =
    pkr_pkg::LEN_W'(pkr_pkg::MAX_KEYWORD_LEN + 1);
  localparam logic [pkr_pkg::LEN_W-1:0] LEN_DEPTH =
    pkr_pkg::LEN_W'(pkr_pkg::MAX_KEYWORD_LEN);
  localparam logic [pkr_pkg::LEN_W-1:0] LEN_KW_MAX =
    pkr_pkg::LEN_W'(pkr_pkg::KW_MAX_LEN);

  // Word state
  pkr_pkg::char_t                  buf_r [pkr_pkg::MAX_KEYWORD_LEN];
  logic [pkr_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [pkr_pkg::LEN_W-1:0]       len_inc;

  // Token register
  logic                            out_valid_r, out_valid_nxt;
  logic [pkr_pkg::CODE_W-1:0]      code_r;

  logic                            accept;
  pkr_pkg::char_t                  ch_lc;
  pkr_pkg::kw_text_t               word;
  logic [pkr_pkg::KW_LEN_W-1:0]    match_len;
  logic [pkr_pkg::CODE_W-1:0]      match_code;

  // Stall input only when a token waits and the sink will not take it.
  assign in_bus.ready = ~out_valid_r | out_bus.ready;
  assign accept       = in_bus.valid & in_bus.ready;
  assign ch_lc        = pkr_pkg::fold_lower(in_bus.ch);

  // Advance the length, hold it once saturated.
  assign len_inc = (len_r < LEN_SAT) ? len_r + pkr_pkg::LEN_W'(1) : len_r;

  // Merge the incoming byte over the buffer so the final byte is compared
  // in its own cycle.
  always_comb begin
    for (int j = 0; j < pkr_pkg::KW_MAX_LEN; j++) begin
      word[j] = (len_r == pkr_pkg::LEN_W'(j)) ? ch_lc : buf_r[j];
    end
  end

  // Lengths past the longest keyword can never match: map them to zero.
  assign match_len = (len_inc <= LEN_KW_MAX) ? pkr_pkg::KW_LEN_W'(len_inc) : '0;

  pkr_match u_match (
    .word (word),
    .len  (match_len),
    .code (match_code)
  );

  // Store the folded byte while there is room; drop bytes past the buffer.
  always_ff @(posedge clk) begin
    if (accept && (len_r < LEN_DEPTH)) begin
      buf_r[len_r[pkr_pkg::IDX_W-1:0]] <= ch_lc;
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (accept) begin
      len_nxt = in_bus.last ? '0 : len_inc;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && in_bus.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the token on the final byte of a word.
  always_ff @(posedge clk) begin
    if (accept && in_bus.last) begin
      code_r <= match_code;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.token_code = code_r;

endmodule

### rtl/core/pkr_match.sv
// Parallel compare of one folded word against the reserved-word table.
module pkr_match (
  input  pkr_pkg::kw_text_t                word,
  input  logic [pkr_pkg::KW_LEN_W-1:0]     len,
  output logic [pkr_pkg::CODE_W-1:0]       code
);

  logic hit;

  // word[i] is letter i of the word; table text holds letter i at len-1-i.
  always_comb begin
    code = pkr_pkg::CODE_IDENT;
    hit  = 1'b0;
    for (int k = 0; k < pkr_pkg::KW_COUNT; k++) begin
      hit = (pkr_pkg::KW_TABLE[k].len == len);
      for (int i = 0; i < pkr_pkg::KW_MAX_LEN; i++) begin
        if (pkr_pkg::KW_LEN_W'(i) < pkr_pkg::KW_TABLE[k].len) begin
          hit = hit & (word[i] == pkr_pkg::KW_TABLE[k].text[
                  pkr_pkg::KW_TABLE[k].len - pkr_pkg::KW_LEN_W'(1)
                  - pkr_pkg::KW_LEN_W'(i)]);
        end
      end
      if (hit) begin
        code = pkr_pkg::CODE_W'(k + 1);
      end
    end
  end

endmodule

### tb/pkr_token_checker.sv
`timescale 1ns / 1ps
// Token checker: watches both channels, predicts token codes, compares them.
module pkr_token_checker
  import pkr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pkr_in_if    in_mon,
  pkr_out_if   out_mon,
  output int   fail_count,
  output int   pending_tokens,
  output int   tokens_checked,
  output int   keyword_tokens
);

  localparam int SAT_LEN = MAX_KEYWORD_LEN + 1;

  // Code of a reserved word is its position here plus one.
  string reserved_words [KW_COUNT] = '{
    "do", "if", "in", "of", "or", "to",
    "and", "div", "end", "for", "mod", "nil", "not", "set", "var",
    "case", "else", "file", "goto", "then", "type", "with",
    "array", "begin", "const", "label", "until", "while",
    "downto", "packed", "record", "repeat",
    "program", "function", "procedure"
  };

  char_t             word_chars [MAX_KEYWORD_LEN];
  int                word_len;
  logic [CODE_W-1:0] expected_tokens [$];

  function automatic char_t to_lower(input char_t c);
    if (c >= 8'd65 && c <= 8'd90) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [CODE_W-1:0] classify_word(input int len);
    bit hit;
    if (len < 2 || len > MAX_KEYWORD_LEN) begin
      return CODE_IDENT;
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      if (reserved_words[k].len() == len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (word_chars[i] != char_t'(reserved_words[k][i])) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          return CODE_W'(k + 1);
        end
      end
    end
    return CODE_IDENT;
  endfunction

  always @(posedge clk) begin : monitor
    logic [CODE_W-1:0] want;
    if (!rst_n) begin
      word_len = 0;
      expected_tokens.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token_code: no word pending, got %0d", out_mon.token_code);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_mon.token_code !== want) begin
            $error("token_code: expected %0d, actual %0d", want, out_mon.token_code);
            fail_count++;
          end
          tokens_checked++;
          if (want != CODE_IDENT) begin
            keyword_tokens++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (word_len < MAX_KEYWORD_LEN) begin
          word_chars[word_len] = to_lower(in_mon.ch);
        end
        if (word_len < SAT_LEN) begin
          word_len++;
        end
        if (in_mon.last) begin
          expected_tokens.push_back(classify_word(word_len));
          word_len = 0;
        end
      end
    end
    pending_tokens = expected_tokens.size();
  end

endmodule

### tb/tb_pascal_keyword_recognizer.sv
`timescale 1ns / 1ps
// Top of the keyword recognizer testbench: clock, reset, word stimulus and verdict.
module tb_pascal_keyword_recognizer;
  import pkr_pkg::*;

  localparam int CHAR_TARGET  = 1650;    // characters to push over the whole run
  localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest legal run
  localparam int DRAIN_CYCLES = 8;       // token register delays each token; allow slack

  typedef char_t word_t [$];

  logic clk = 1'b0;
  logic rst_n;

  pkr_in_if  char_bus ();
  pkr_out_if token_bus ();

  int send_idle_pct;
  int recv_idle_pct;
  int chars_sent;
  int words_sent;
  int long_words;
  int cycle_count;
  int fail_count;
  int pending_tokens;
  int tokens_checked;
  int keyword_tokens;

  pascal_keyword_recognizer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (char_bus),
    .out_bus (token_bus)
  );

  pkr_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (char_bus),
    .out_mon        (token_bus),
    .fail_count     (fail_count),
    .pending_tokens (pending_tokens),
    .tokens_checked (tokens_checked),
    .keyword_tokens (keyword_tokens)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: drop ready at random at the current stall rate; hold it low in reset.
  always @(posedge clk) begin
    token_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic char_t rand_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 26) begin
      return char_t'(8'd97 + r);
    end else if (r < 52) begin
      return char_t'(8'd65 + r - 26);
    end
    return char_t'(8'd48 + r - 52);
  endfunction

  function automatic word_t text_word(input string s);
    word_t w;
    for (int i = 0; i < s.len(); i++) begin
      w.push_back(char_t'(s[i]));
    end
    return w;
  endfunction

  // Reserved word k, each letter raised to upper case at random.
  // Table text is right-justified: first letter in the highest used byte.
  function automatic word_t keyword_word(input int k);
    word_t w;
    int    len;
    char_t c;
    len = KW_TABLE[k].len;
    for (int i = 0; i < len; i++) begin
      c = KW_TABLE[k].text[len-1-i];
      if ($urandom_range(1) == 1) begin
        c = c - 8'd32;
      end
      w.push_back(c);
    end
    return w;
  endfunction

  // Reserved word with one letter swapped, one appended or the last one cut.
  function automatic word_t near_miss_word(input int k);
    word_t w;
    w = keyword_word(k);
    case ($urandom_range(2))
      0: w[$urandom_range(w.size() - 1)] = rand_alnum();
      1: w.push_back(rand_alnum());
      default: begin
        if (w.size() > 1) begin
          void'(w.pop_back());
        end
      end
    endcase
    return w;
  endfunction

  // Letters and digits; now and then long enough to saturate the length count.
  function automatic word_t ident_word();
    word_t w;
    int    len;
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
    for (int i = 0; i < len; i++) begin
      w.push_back(rand_alnum());
    end
    return w;
  endfunction

  function automatic word_t raw_word();
    word_t w;
    int    len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      w.push_back(char_t'($urandom_range(255)));
    end
    return w;
  endfunction

  // Send one word, a beat per character, last on the final one. Idle gaps go
  // in front of any beat, so they fall inside words as well as between them.
  task automatic send_word(input word_t w);
    for (int i = 0; i < w.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        char_bus.valid <= 1'b0;
        @(posedge clk);
      end
      char_bus.valid <= 1'b1;
      char_bus.ch    <= w[i];
      char_bus.last  <= (i == w.size() - 1);
      do @(posedge clk); while (!char_bus.ready);
    end
    chars_sent += w.size();
    words_sent++;
    if (w.size() > MAX_KEYWORD_LEN) begin
      long_words++;
    end
  endtask

  // Hold the sender off until every predicted token has left the block.
  task automatic wait_tokens_drained();
    char_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_tokens != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    word_t w;
    int    phase;
    int    pick;

    char_bus.valid  <= 1'b0;
    char_bus.ch     <= '0;
    char_bus.last   <= 1'b0;
    rst_n           <= 1'b0;
    send_idle_pct   = 21;
    recv_idle_pct   = 60;
    phase           = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: longest keyword in capitals, a mixed-case "do", a lone letter,
    // the bytes just outside both letter ranges, the byte extremes, and a
    // keyword prefix pushed past the buffer depth.
    send_word(text_word("PROCEDURE"));
    send_word(text_word("Do"));
    send_word(text_word("q"));
    w = '{8'h40, 8'h5B, 8'h60, 8'h7B};
    send_word(w);
    w = '{8'h00, 8'hFF};
    send_word(w);
    send_word(text_word("ProgramXYZ"));

    // Every reserved word once, in random case.
    for (int k = 0; k < KW_COUNT; k++) begin
      send_word(keyword_word(k));
    end

    // Random mix: mostly words near the keyword set, the rest noise.
    while (chars_sent < CHAR_TARGET) begin
      if (phase == 0 && chars_sent >= CHAR_TARGET / 3) begin
        wait_tokens_drained();
        send_idle_pct = 60;
        recv_idle_pct = 21;
        phase         = 1;
      end else if (phase == 1 && chars_sent >= 2 * CHAR_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase         = 2;
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_word(keyword_word($urandom_range(KW_COUNT - 1)));
      end else if (pick < 60) begin
        send_word(near_miss_word($urandom_range(KW_COUNT - 1)));
      end else if (pick < 85) begin
        send_word(ident_word());
      end else begin
        send_word(raw_word());
      end
    end

    // Drain, then give a stray token time to show up.
    wait_tokens_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run sent %0d characters in %0d words, %0d of them past the buffer depth,",
             chars_sent, words_sent, long_words);
    $display("under three stall mixes; %0d tokens checked, %0d reserved words among them.",
             tokens_checked, keyword_tokens);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### pascal_keyword_recognizer.f
rtl/core/pkr_pkg.sv
rtl/core/pkr_if.sv
rtl/core/pkr_match.sv
rtl/core/pascal_keyword_recognizer.sv
tb/pkr_token_checker.sv
tb/tb_pascal_keyword_recognizer.sv
